[rtl/voa_pkg.sv]
// shared constants and payload types for the oldest-note voice allocator
`default_nettype none

package voa_pkg;

   localparam int NOTE_COUNT = 128;
   localparam int TIME_BITS  = 32;
   localparam int NOTE_BITS  = $clog2(NOTE_COUNT);
   localparam int CNT_BITS   = $clog2(NOTE_COUNT + 1);
   localparam logic [7:0] POLY_RESET = 8'd16;

   typedef struct packed {
      logic       mode;
      logic [6:0] note;
   } req_type;

   typedef struct packed {
      logic       stole;
      logic [6:0] stolen_note;
      logic [7:0] active_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   localparam logic MODE_OFF = 1'b0;
   localparam logic MODE_ON  = 1'b1;

endpackage

`default_nettype wire

[rtl/voa_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module voa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/voice_allocator_oldest_steal.sv]
// top level of the oldest-note-stealing voice allocator
`default_nettype none

// Tracks which of the 128 notes are active and when each started. A note-off,
// or a note-on that finds the active count below max_polyphony or at zero, goes
// from idle straight to the finish state and commits there once the output
// register is free. When the count is nonzero and has reached the limit, the
// block first walks the start-time ram one entry per cycle to find the oldest
// active note (lowest note number on a tie); the single read port of the
// start-time ram sets the pace of that walk. One item is processed at a
// time; a new item is taken as soon as the previous one has been committed, even
// while its result still waits in the output register, and the next commit waits
// until that result has been taken. Exactly one result comes back per item, and
// at most one note is stolen per note-on. csr writes are always accepted and
// must only happen while the block is idle.
module voice_allocator_oldest_steal (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire voa_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output voa_pkg::rsp_type     rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [7:0]      csr_data
);

   voa_pkg::state_type state_ff, state_in;

   logic [voa_pkg::NOTE_COUNT-1:0] active_ff, active_in;
   logic [voa_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [voa_pkg::TIME_BITS-1:0]  time_ff, time_in;
   logic [7:0]                     max_poly_ff, max_poly_in;

   logic                           mode_ff, mode_in;
   logic                           note_ok_ff, note_ok_in;
   logic [voa_pkg::NOTE_BITS-1:0]  note_ff, note_in;

   logic [voa_pkg::NOTE_BITS:0]    scan_cnt_ff, scan_cnt_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [voa_pkg::NOTE_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic                           found_ff, found_in;
   logic [voa_pkg::NOTE_BITS-1:0]  victim_ff, victim_in;
   logic [voa_pkg::TIME_BITS-1:0]  best_ff, best_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   voa_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                           ram_we;
   logic [voa_pkg::TIME_BITS-1:0]  ram_wdata;
   logic                           ram_re;
   logic [voa_pkg::TIME_BITS-1:0]  ram_rdata;

   logic                           req_fire;
   logic                           out_free;
   logic                           commit;
   logic                           arg_note_ok;
   logic                           cand;
   logic                           keep_active;
   logic [voa_pkg::CNT_BITS-1:0]   count_on;

   voa_ram #(
      .WIDTH (voa_pkg::TIME_BITS),
      .DEPTH (voa_pkg::NOTE_COUNT)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (note_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (scan_cnt_ff[voa_pkg::NOTE_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == voa_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == voa_pkg::S_FINISH) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign arg_note_ok = ({1'b0, req_data.note} < 8'(voa_pkg::NOTE_COUNT));

   // reads only happen during the scan and writes only at commit, so the
   // state machine keeps the two from touching the ram in the same cycle
   assign ram_re = (state_ff == voa_pkg::S_SCAN) &&
                   (scan_cnt_ff < (voa_pkg::NOTE_BITS + 1)'(voa_pkg::NOTE_COUNT));
   assign ram_we = commit && note_ok_ff && (mode_ff == voa_pkg::MODE_ON);
   assign ram_wdata = time_ff + voa_pkg::TIME_BITS'(found_ff);

   // a scanned entry beats the current best only if strictly older
   assign cand = rd_valid_ff && active_ff[rd_idx_ff] && (!found_ff || (ram_rdata < best_ff));

   // the new note is already counted if it stays active through the steal
   assign keep_active = active_ff[note_ff] && !(found_ff && (victim_ff == note_ff));
   assign count_on    = count_ff - voa_pkg::CNT_BITS'(found_ff)
                        + voa_pkg::CNT_BITS'(!keep_active);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      max_poly_in  = max_poly_ff;
      mode_in      = mode_ff;
      note_ok_in   = note_ok_ff;
      note_in      = note_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = scan_cnt_ff[voa_pkg::NOTE_BITS-1:0];
      found_in     = found_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         max_poly_in = csr_data;
      end

      case (state_ff)
         voa_pkg::S_IDLE: begin
            if (req_fire) begin
               mode_in     = req_data.mode;
               note_ok_in  = arg_note_ok;
               note_in     = req_data.note[voa_pkg::NOTE_BITS-1:0];
               found_in    = 1'b0;
               victim_in   = '0;
               scan_cnt_in = '0;
               state_in    = voa_pkg::S_FINISH;
               if (arg_note_ok && (req_data.mode == voa_pkg::MODE_ON)) begin
                  time_in = time_ff + voa_pkg::TIME_BITS'(1);
                  if ((8'(count_ff) >= max_poly_ff) && (count_ff != '0)) begin
                     state_in = voa_pkg::S_SCAN;
                  end
               end
            end
         end
         voa_pkg::S_SCAN: begin
            if (ram_re) begin
               scan_cnt_in = scan_cnt_ff + (voa_pkg::NOTE_BITS + 1)'(1);
               rd_valid_in = 1'b1;
            end
            if (cand) begin
               found_in  = 1'b1;
               victim_in = rd_idx_ff;
               best_in   = ram_rdata;
            end
            if (rd_valid_ff &&
                (rd_idx_ff == voa_pkg::NOTE_BITS'(voa_pkg::NOTE_COUNT - 1))) begin
               state_in = voa_pkg::S_FINISH;
            end
         end
         voa_pkg::S_FINISH: begin
            if (commit) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.stole        = found_ff;
               rsp_data_in.stolen_note  = 7'(victim_ff);
               rsp_data_in.active_count = 8'(count_ff);
               if (note_ok_ff) begin
                  if (mode_ff == voa_pkg::MODE_ON) begin
                     if (found_ff) begin
                        active_in[victim_ff] = 1'b0;
                     end
                     active_in[note_ff]       = 1'b1;
                     time_in                  = ram_wdata;
                     count_in                 = count_on;
                     rsp_data_in.active_count = 8'(count_on);
                  end else begin
                     active_in[note_ff] = 1'b0;
                     count_in = count_ff - voa_pkg::CNT_BITS'(active_ff[note_ff]);
                     rsp_data_in.active_count =
                        8'(count_ff - voa_pkg::CNT_BITS'(active_ff[note_ff]));
                  end
               end
               state_in = voa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = voa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= voa_pkg::S_IDLE;
         active_ff    <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         max_poly_ff  <= voa_pkg::POLY_RESET;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         max_poly_ff  <= max_poly_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      note_ok_ff  <= note_ok_in;
      note_ff     <= note_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      victim_ff   <= victim_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   // running count must match the active flags
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == voa_pkg::CNT_BITS'($countones(active_ff)))
      else $error("active count out of step with active flags");

   // a chosen victim is an active note when the item commits
   a_victim_active: assert property (@(posedge clock) disable iff (reset)
      (commit && found_ff) |-> active_ff[victim_ff])
      else $error("stolen note is not active");

   // only note-ons scan the ram
   a_scan_note_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == voa_pkg::S_SCAN) |-> (mode_ff == voa_pkg::MODE_ON))
      else $error("scan started for a note-off");

   // a result is loaded only into a free output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the oldest-note-stealing voice allocator
`timescale 1ns / 1ps

module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_COUNT    = 9;
   localparam int PEND_DEPTH     = 16;

   // per-phase polyphony limit (last phase draws its own), note-on share and length
   localparam logic [7:0] PHASE_LIMIT [PHASE_COUNT] =
      '{8'd16, 8'd1, 8'd128, 8'd0, 8'd255, 8'd4, 8'd64, 8'd2, 8'd0};
   localparam int PHASE_ON_PCT [PHASE_COUNT] = '{60, 60, 95, 55, 70, 60, 85, 60, 65};
   localparam int PHASE_ITEMS [PHASE_COUNT] = '{150, 150, 220, 150, 150, 150, 150, 130, 100};

   typedef enum bit {ROW_EVENT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [7:0]       limit;
      voa_pkg::req_type item;
      logic             typed;
      voa_pkg::rsp_type want;
   } script_row_type;

   localparam int SCRIPT_LEN = 24;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_OFF, 7'd0},   1'b1, '{1'b0, 7'd0, 8'd0}},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd0},   1'b1, '{1'b0, 7'd0, 8'd1}},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd127}, 1'b1, '{1'b0, 7'd0, 8'd2}},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_OFF, 7'd127}, 1'b1, '{1'b0, 7'd0, 8'd1}},
      // note-off of a note that is already off
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_OFF, 7'd127}, 1'b1, '{1'b0, 7'd0, 8'd1}},
      // retrigger below the limit
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd0},   1'b1, '{1'b0, 7'd0, 8'd1}},
      '{ROW_CSR,   8'd1,   '0,                           1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd5},   1'b1, '{1'b1, 7'd0, 8'd1}},
      // retrigger of the oldest note steals itself
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd5},   1'b1, '{1'b1, 7'd5, 8'd1}},
      '{ROW_CSR,   8'd0,   '0,                           1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_OFF, 7'd5},   1'b1, '{1'b0, 7'd0, 8'd0}},
      // limit zero with nothing active: nothing to steal
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd9},   1'b1, '{1'b0, 7'd0, 8'd1}},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd10},  1'b1, '{1'b1, 7'd9, 8'd1}},
      '{ROW_CSR,   8'd255, '0,                           1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd20},  1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd21},  1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd22},  1'b0, '0},
      // limit dropped below the active count: still one steal only
      '{ROW_CSR,   8'd1,   '0,                           1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd40},  1'b0, '0},
      '{ROW_CSR,   8'd128, '0,                           1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd127}, 1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_OFF, 7'd0},   1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd85},  1'b0, '0},
      '{ROW_EVENT, 8'd0,   '{voa_pkg::MODE_ON,  7'd42},  1'b0, '0}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   voa_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   voa_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [7:0]       csr_data;

   // allocator state as the testbench sees it
   bit                          note_live [voa_pkg::NOTE_COUNT];
   bit [voa_pkg::TIME_BITS-1:0] note_stamp [voa_pkg::NOTE_COUNT];
   bit [voa_pkg::TIME_BITS-1:0] stamp_clock = '0;
   bit [7:0]                    poly_limit = voa_pkg::POLY_RESET;

   // ring of expected results, oldest first
   voa_pkg::rsp_type pend_ring [PEND_DEPTH];
   int unsigned      pend_wr = 0;
   int unsigned      pend_rd = 0;

   int unsigned error_count = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   logic [9:0]  rsp_cycle = '0;

   voice_allocator_oldest_steal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned pending_count();
      return pend_wr - pend_rd;
   endfunction

   function automatic int unsigned live_count();
      int unsigned n;
      n = 0;
      for (int i = 0; i < voa_pkg::NOTE_COUNT; i++)
         if (note_live[i])
            n++;
      return n;
   endfunction

   function automatic voa_pkg::rsp_type predict_allocation(input voa_pkg::req_type item);
      voa_pkg::rsp_type            res;
      bit                          found;
      int unsigned                 victim;
      bit [voa_pkg::TIME_BITS-1:0] oldest;
      res = '0;
      found = 1'b0;
      victim = 0;
      oldest = '0;
      if (item.mode == voa_pkg::MODE_OFF) begin
         note_live[item.note] = 1'b0;
      end else begin
         stamp_clock++;
         if (live_count() >= poly_limit) begin
            for (int i = 0; i < voa_pkg::NOTE_COUNT; i++) begin
               if (note_live[i] && (!found || note_stamp[i] < oldest)) begin
                  found = 1'b1;
                  oldest = note_stamp[i];
                  victim = i;
               end
            end
            if (found) begin
               note_live[victim] = 1'b0;
               stamp_clock++;
               res.stole = 1'b1;
               res.stolen_note = 7'(victim);
            end
         end
         note_live[item.note] = 1'b1;
         note_stamp[item.note] = stamp_clock;
      end
      res.active_count = 8'(live_count());
      return res;
   endfunction

   // first note at or after a random start whose active flag matches
   function automatic logic [6:0] pick_note(input bit want_live);
      int unsigned start;
      int unsigned idx;
      start = $urandom_range(0, voa_pkg::NOTE_COUNT - 1);
      for (int k = 0; k < voa_pkg::NOTE_COUNT; k++) begin
         idx = (start + k) % voa_pkg::NOTE_COUNT;
         if (note_live[idx] == want_live)
            return 7'(idx);
      end
      return 7'(start);
   endfunction

   // mostly note-ons of silent notes and note-offs of sounding ones, the rest arbitrary
   function automatic voa_pkg::req_type random_event(input int unsigned on_pct);
      voa_pkg::req_type ev;
      ev.mode = ($urandom_range(0, 99) < on_pct) ? voa_pkg::MODE_ON : voa_pkg::MODE_OFF;
      if ($urandom_range(0, 3) == 0)
         ev.note = 7'($urandom_range(0, voa_pkg::NOTE_COUNT - 1));
      else
         ev.note = pick_note(ev.mode == voa_pkg::MODE_OFF);
      return ev;
   endfunction

   task automatic drive_event(input voa_pkg::req_type item, input logic typed,
                              input voa_pkg::rsp_type want);
      int unsigned      gap;
      voa_pkg::rsp_type guess;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_allocation(item);
      pend_ring[pend_wr % PEND_DEPTH] = typed ? want : guess;
      pend_wr++;
   endtask

   // limit changes only once the block has drained
   task automatic write_poly_limit(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      poly_limit = value;
   endtask

   initial begin
      script_row_type row;
      logic [7:0]     limit;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         row = SCRIPT[r];
         if (row.kind == ROW_CSR)
            write_poly_limit(row.limit);
         else
            drive_event(row.item, row.typed, row.want);
      end
      for (int p = 0; p < PHASE_COUNT; p++) begin
         limit = (p == PHASE_COUNT - 1) ? 8'($urandom_range(0, 255)) : PHASE_LIMIT[p];
         write_poly_limit(limit);
         for (int n = 0; n < PHASE_ITEMS[p]; n++)
            drive_event(random_event(PHASE_ON_PCT[p]), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (pending_count() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // receiver: free-flowing, light stalls, heavy stalls, long stalls in turn
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1'b1;
      case (rsp_cycle[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= (rsp_cycle[4:2] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      voa_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_count() == 0) begin
            $display("%0t: result with none pending, got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pend_ring[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_data.stole !== want.stole) begin
               $display("%0t: stole mismatch, expected %0d got %0d",
                        $time, want.stole, rsp_data.stole);
               error_count++;
            end
            if (rsp_data.stolen_note !== want.stolen_note) begin
               $display("%0t: stolen_note mismatch, expected %0d got %0d",
                        $time, want.stolen_note, rsp_data.stolen_note);
               error_count++;
            end
            if (rsp_data.active_count !== want.active_count) begin
               $display("%0t: active_count mismatch, expected %0d got %0d",
                        $time, want.active_count, rsp_data.active_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
